### src/mbc_pkg.sv
// Package for the maze carver: configuration defaults, codes and transaction payload types.
package mbc_pkg;

  localparam int MBC_MAX_ROWS    = 32;
  localparam int MBC_MAX_COLS    = 32;
  localparam int MBC_STACK_DEPTH = 256;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] CELL_WALL    = 2'd0;
  localparam logic [1:0] CELL_PASSAGE = 2'd1;
  localparam logic [1:0] CELL_ENTER   = 2'd2;
  localparam logic [1:0] CELL_EXIT    = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [5:0] ROWS_RESET = 6'd32;
  localparam logic [5:0] COLS_RESET = 6'd32;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] enter_col;
    logic [4:0] exit_col;
    logic [7:0] rand_req;
    logic [4:0] read_row;
    logic [4:0] read_col;
  } mbc_in_t;

  typedef struct packed {
    logic [1:0] cell_res;
    logic       done_res;
    logic       carved;
    logic [4:0] top_row;
    logic [4:0] top_col;
    logic       bad_request;
  } mbc_out_t;

endpackage

### src/maze_backtracker_carver_top.sv
// Maze carver top level: grid and path stack memories with the carving sequencer.
// One command is handled at a time. A read fetches one cell from the grid memory. A step
// makes four neighbour reads of the grid memory; when it carves it then makes two writes,
// and when it backtracks it pops the path stack. An unused command or a bad start goes
// straight to the result. A good start sweeps the grid memory, then writes three cells.
// After reset the grid is cleared by the same sweep before any input transaction is
// accepted; configuration writes are taken at all times.
module maze_backtracker_carver_top
  import mbc_pkg::*;
#(
  parameter int MAX_ROWS    = MBC_MAX_ROWS,
  parameter int MAX_COLS    = MBC_MAX_COLS,
  parameter int STACK_DEPTH = MBC_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  mbc_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output mbc_out_t   out_data
);

  localparam int CRW    = $clog2(MAX_ROWS);
  localparam int CCW    = $clog2(MAX_COLS);
  localparam int GDEPTH = MAX_ROWS * MAX_COLS;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int CNTW   = $clog2(STACK_DEPTH + 1);
  localparam int MAXD   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DWR    = $clog2(MAXD + 4);
  localparam int DW     = (DWR > 6) ? DWR : 6;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_W = 2'd2;
  localparam logic [1:0] DIR_E = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INIT_E, S_INIT_X, S_INIT_P, S_RD_W, S_NB, S_NB_END,
    S_CARVE1, S_CARVE2, S_POP_LD, S_OUT
  } state_t;

  state_t          state_r;
  logic [GAW-1:0]  clr_addr_r;
  logic            start_pend_r;
  logic [5:0]      rows_cfg_r;
  logic [5:0]      cols_cfg_r;
  mbc_in_t         in_r;
  logic [CNTW-1:0] count_r;
  logic [CRW-1:0]  top_row_r;
  logic [CCW-1:0]  top_col_r;
  logic [1:0]      dir_r;
  logic [2:0]      open_r;
  logic            rd_ok_r;
  logic [CRW-1:0]  new_row_r;
  logic [CCW-1:0]  new_col_r;
  logic [GAW-1:0]  new_addr_r;
  logic [GAW-1:0]  mid_addr_r;
  logic [1:0]      res_cell_r;
  logic            res_carved_r;
  logic            res_bad_r;
  logic            out_valid_r;
  mbc_out_t        out_data_r;

  logic [1:0]           grid_mem [GDEPTH];
  logic [CRW+CCW-1:0]   stack_mem [STACK_DEPTH];
  logic [1:0]           g_rdata_r;
  logic [CRW+CCW-1:0]   s_rdata_r;

  logic                 g_we;
  logic [GAW-1:0]       g_waddr;
  logic [1:0]           g_wdata;
  logic [GAW-1:0]       g_raddr;
  logic                 s_we;
  logic [SAW-1:0]       s_waddr;
  logic [CRW+CCW-1:0]   s_wdata;
  logic [SAW-1:0]       s_raddr;

  logic                 in_acc;
  logic [DW-1:0]        rows_d;
  logic [DW-1:0]        cols_d;
  logic [DW-1:0]        r_d;
  logic [DW-1:0]        c_d;
  logic                 row_ok;
  logic                 col_ok;
  logic [3:0]           inb;
  logic [CRW-1:0]       nb_row [4];
  logic [CCW-1:0]       nb_col [4];
  logic [CRW-1:0]       mid_row [4];
  logic [CCW-1:0]       mid_col [4];
  logic [GAW-1:0]       nb_addr [4];
  logic [3:0]           mask;
  logic [2:0]           n_open;
  logic [1:0]           pick_j;
  logic [1:0]           pick_k;
  logic                 stack_full;
  logic                 start_ok;
  logic [DW-1:0]        ec_d;
  logic [DW-1:0]        xc_d;
  logic [CCW+4:0]       ec_ext;
  logic [CCW+4:0]       xc_ext;
  logic [CCW-1:0]       ec_c;
  logic [CCW-1:0]       xc_c;
  logic [CRW-1:0]       last_row;
  logic [CRW+4:0]       rr_ext;
  logic [CCW+4:0]       rc_ext;
  logic                 rd_in_store;
  logic [GAW-1:0]       rd_addr;
  logic [CRW+4:0]       top_row_ext;
  logic [CCW+4:0]       top_col_ext;

  function automatic logic [GAW-1:0] cell_addr(input logic [CRW-1:0] r,
                                               input logic [CCW-1:0] c);
    return GAW'(r) * GAW'(MAX_COLS) + GAW'(c);
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [5:0] v, input logic [DW-1:0] mx);
    logic [DW-1:0] ve;
    ve = DW'(v);
    if (ve < DW'(3)) begin
      return DW'(3);
    end else if (ve > mx) begin
      return mx;
    end
    return ve;
  endfunction

  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd6) begin
      return 2'(t - 3'd6);
    end else if (t >= 3'd3) begin
      return 2'(t - 3'd3);
    end
    return t[1:0];
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rows_d = clamp_dim(rows_cfg_r, DW'(MAX_ROWS));
  assign cols_d = clamp_dim(cols_cfg_r, DW'(MAX_COLS));

  assign r_d    = DW'(top_row_r);
  assign c_d    = DW'(top_col_r);
  assign row_ok = (r_d != '0) && (r_d + DW'(1) < rows_d);
  assign col_ok = (c_d != '0) && (c_d + DW'(1) < cols_d);

  always_comb begin
    inb[DIR_N] = (r_d > DW'(2)) && (r_d <= rows_d) && col_ok;
    inb[DIR_S] = (r_d + DW'(3) < rows_d) && col_ok;
    inb[DIR_W] = (c_d > DW'(2)) && (c_d <= cols_d) && row_ok;
    inb[DIR_E] = (c_d + DW'(3) < cols_d) && row_ok;

    nb_row[DIR_N]  = top_row_r - CRW'(2);
    nb_col[DIR_N]  = top_col_r;
    nb_row[DIR_S]  = top_row_r + CRW'(2);
    nb_col[DIR_S]  = top_col_r;
    nb_row[DIR_W]  = top_row_r;
    nb_col[DIR_W]  = top_col_r - CCW'(2);
    nb_row[DIR_E]  = top_row_r;
    nb_col[DIR_E]  = top_col_r + CCW'(2);
    mid_row[DIR_N] = top_row_r - CRW'(1);
    mid_col[DIR_N] = top_col_r;
    mid_row[DIR_S] = top_row_r + CRW'(1);
    mid_col[DIR_S] = top_col_r;
    mid_row[DIR_W] = top_row_r;
    mid_col[DIR_W] = top_col_r - CCW'(1);
    mid_row[DIR_E] = top_row_r;
    mid_col[DIR_E] = top_col_r + CCW'(1);
    for (int d = 0; d < 4; d++) begin
      nb_addr[d] = cell_addr(nb_row[d], nb_col[d]);
    end
  end

  always_comb begin
    logic [2:0] seen;
    mask   = {inb[DIR_E] && (g_rdata_r == CELL_WALL), open_r};
    n_open = 3'($countones(mask));
    case (n_open)
      3'd2:    pick_j = {1'b0, in_r.rand_req[0]};
      3'd3:    pick_j = mod3(in_r.rand_req);
      3'd4:    pick_j = in_r.rand_req[1:0];
      default: pick_j = 2'd0;
    endcase
    seen   = 3'd0;
    pick_k = DIR_N;
    for (int d = 0; d < 4; d++) begin
      if (mask[d]) begin
        if (seen == {1'b0, pick_j}) begin
          pick_k = 2'(d);
        end
        seen = seen + 3'd1;
      end
    end
  end

  assign stack_full = (count_r >= CNTW'(STACK_DEPTH));

  assign ec_d     = DW'(in_data.enter_col);
  assign xc_d     = DW'(in_data.exit_col);
  assign start_ok = (ec_d != '0) && (ec_d + DW'(2) <= cols_d) &&
                    (xc_d != '0) && (xc_d + DW'(2) <= cols_d);
  assign ec_ext   = {{CCW{1'b0}}, in_r.enter_col};
  assign xc_ext   = {{CCW{1'b0}}, in_r.exit_col};
  assign ec_c     = ec_ext[CCW-1:0];
  assign xc_c     = xc_ext[CCW-1:0];
  assign last_row = CRW'(rows_d - DW'(1));

  assign rr_ext      = {{CRW{1'b0}}, in_data.read_row};
  assign rc_ext      = {{CCW{1'b0}}, in_data.read_col};
  assign rd_in_store = (DW'(in_data.read_row) < DW'(MAX_ROWS)) &&
                       (DW'(in_data.read_col) < DW'(MAX_COLS));
  assign rd_addr     = cell_addr(rr_ext[CRW-1:0], rc_ext[CCW-1:0]);

  assign top_row_ext = {5'b0, top_row_r};
  assign top_col_ext = {5'b0, top_col_r};

  always_comb begin
    g_we    = 1'b0;
    g_waddr = clr_addr_r;
    g_wdata = CELL_WALL;
    s_we    = 1'b0;
    s_waddr = count_r[SAW-1:0];
    s_wdata = {new_row_r, new_col_r};
    s_raddr = SAW'(count_r - CNTW'(2));
    if (state_r == S_IDLE) begin
      g_raddr = (in_data.cmd == CMD_READ) ? rd_addr : nb_addr[DIR_N];
    end else begin
      g_raddr = nb_addr[dir_r];
    end
    unique case (state_r)
      S_CLEAR: begin
        g_we = 1'b1;
      end
      S_INIT_E: begin
        g_we    = 1'b1;
        g_waddr = cell_addr('0, ec_c);
        g_wdata = CELL_ENTER;
      end
      S_INIT_X: begin
        g_we    = 1'b1;
        g_waddr = cell_addr(last_row, xc_c);
        g_wdata = CELL_EXIT;
      end
      S_INIT_P: begin
        g_we    = 1'b1;
        g_waddr = cell_addr(CRW'(1), ec_c);
        g_wdata = CELL_PASSAGE;
        s_we    = 1'b1;
        s_waddr = '0;
        s_wdata = {CRW'(1), ec_c};
      end
      S_CARVE1: begin
        g_we    = 1'b1;
        g_waddr = new_addr_r;
        g_wdata = CELL_PASSAGE;
      end
      S_CARVE2: begin
        g_we    = 1'b1;
        g_waddr = mid_addr_r;
        g_wdata = CELL_PASSAGE;
        s_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    g_rdata_r <= grid_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    s_rdata_r <= stack_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      start_pend_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      rows_cfg_r   <= ROWS_RESET;
      cols_cfg_r   <= COLS_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: rows_cfg_r <= cfg_wdata;
          REG_COLS: cols_cfg_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == GAW'(GDEPTH - 1)) begin
            clr_addr_r <= '0;
            state_r    <= start_pend_r ? S_INIT_E : S_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + GAW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            in_r         <= in_data;
            res_cell_r   <= CELL_WALL;
            res_carved_r <= 1'b0;
            res_bad_r    <= 1'b0;
            dir_r        <= DIR_S;
            rd_ok_r      <= rd_in_store;
            unique case (in_data.cmd)
              CMD_START: begin
                if (start_ok) begin
                  start_pend_r <= 1'b1;
                  state_r      <= S_CLEAR;
                end else begin
                  res_bad_r <= 1'b1;
                  state_r   <= S_OUT;
                end
              end
              CMD_STEP: begin
                state_r <= (count_r == '0) ? S_OUT : S_NB;
              end
              CMD_READ: begin
                state_r <= S_RD_W;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_INIT_E: begin
          state_r <= S_INIT_X;
        end
        S_INIT_X: begin
          state_r <= S_INIT_P;
        end
        S_INIT_P: begin
          start_pend_r <= 1'b0;
          top_row_r    <= CRW'(1);
          top_col_r    <= ec_c;
          count_r      <= CNTW'(1);
          state_r      <= S_OUT;
        end
        S_RD_W: begin
          res_cell_r <= rd_ok_r ? g_rdata_r : CELL_WALL;
          state_r    <= S_OUT;
        end
        S_NB: begin
          open_r[dir_r - 2'd1] <= inb[dir_r - 2'd1] && (g_rdata_r == CELL_WALL);
          dir_r                <= dir_r + 2'd1;
          if (dir_r == DIR_E) begin
            state_r <= S_NB_END;
          end
        end
        S_NB_END: begin
          if (n_open == 3'd0 || stack_full) begin
            count_r <= count_r - CNTW'(1);
            state_r <= (count_r == CNTW'(1)) ? S_OUT : S_POP_LD;
          end else begin
            new_row_r  <= nb_row[pick_k];
            new_col_r  <= nb_col[pick_k];
            new_addr_r <= nb_addr[pick_k];
            mid_addr_r <= cell_addr(mid_row[pick_k], mid_col[pick_k]);
            state_r    <= S_CARVE1;
          end
        end
        S_CARVE1: begin
          state_r <= S_CARVE2;
        end
        S_CARVE2: begin
          top_row_r    <= new_row_r;
          top_col_r    <= new_col_r;
          count_r      <= count_r + CNTW'(1);
          res_carved_r <= 1'b1;
          state_r      <= S_OUT;
        end
        S_POP_LD: begin
          top_row_r <= s_rdata_r[CRW+CCW-1:CCW];
          top_col_r <= s_rdata_r[CCW-1:0];
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.cell_res    <= res_cell_r;
            out_data_r.done_res    <= (count_r == '0);
            out_data_r.carved      <= res_carved_r;
            out_data_r.top_row     <= (count_r == '0) ? 5'd0 : top_row_ext[4:0];
            out_data_r.top_col     <= (count_r == '0) ? 5'd0 : top_col_ext[4:0];
            out_data_r.bad_request <= res_bad_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !g_we)
    else $error("grid written while idle");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE2) |=> (count_r == $past(count_r) + CNTW'(1)))
    else $error("push did not advance stack count");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE2) |-> !stack_full)
    else $error("push on full stack");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result overwrote a pending transaction");

endmodule
